[hw/rtl/life_cell_update_engine_macros.svh]
// Assertion macros for the life cell update engine.
// Needs clk and rst_n in the scope of each use; empty when SYNTH is set.
`ifndef LIFE_CELL_UPDATE_ENGINE_MACROS_SVH
`define LIFE_CELL_UPDATE_ENGINE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCU_ASSERT_NOW(label, ante, cons, msg)
`define LCU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/lcu_pkg.sv]
// Shared types and constants for the life cell update engine.
// No dependencies; imported by life_cell_update_engine.
`timescale 1ns / 1ps

package lcu_pkg;

  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  localparam logic [7:0] X_LOW_RST  = 8'd0;
  localparam logic [7:0] X_HIGH_RST = 8'd239;
  localparam logic [7:0] Y_LOW_RST  = 8'd0;
  localparam logic [7:0] Y_HIGH_RST = 8'd159;

  // live-neighbour counts used by the rule
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_MIN = 4'd2;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_X_LOW  = 2'd0,
    REG_X_HIGH = 2'd1,
    REG_Y_LOW  = 2'd2,
    REG_Y_HIGH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_MID,
    ST_RD_UP,
    ST_RD_DN,
    ST_CAP_DN,
    ST_CALC,
    ST_WB
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic       cell_value;
  } in_item_t;

  typedef struct packed {
    logic       alive;
    logic [3:0] live_count;
    logic [7:0] neighbour_mask;
  } out_item_t;

endpackage

[hw/rtl/life_cell_update_engine.sv]
// Life cell update engine: row-wide grid memory with a read-modify-write sequencer.
// Depends on lcu_pkg and life_cell_update_engine_macros.svh.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | in_data  (lcu_pkg::in_item_t)
//  out_    | out | out_valid/out_stall| out_data (lcu_pkg::out_item_t)
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// Each item passes through three row reads and one row write-back on the
// single-port grid memory, plus capture and rule evaluation.
// After reset a clearing pass writes GRID_ROWS rows before the first item is
// taken. A result waits in the output register; a new item is taken meanwhile
// and holds in write-back until the waiting beat leaves.
`timescale 1ns / 1ps
`include "life_cell_update_engine_macros.svh"

module life_cell_update_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lcu_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import lcu_pkg::*;

  // grid storage: one word per row
  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] mem_q;
  logic [GRID_COLS-1:0] mem_wdata;
  logic [ROW_W-1:0]     mem_addr;
  logic                 mem_we;

  state_t state_r, state_nxt;
  logic [ROW_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0] x_low_r, x_low_nxt, x_high_r, x_high_nxt;
  logic [7:0] y_low_r, y_low_nxt, y_high_r, y_high_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;

  in_item_t             item_r;
  logic [GRID_COLS-1:0] up_r, mid_r, dn_r;
  logic [7:0]           mask_r;
  logic [3:0]           count_r;
  logic                 alive_r;

  logic       accept;
  logic       wb_go;
  logic [8:0] col9, row9;
  logic       col_ok, row_ok, colm_ok, colp_ok, up_ok, dn_ok;
  logic       use_l, use_r, use_u, use_d;
  logic [COL_W-1:0] col_c, col_m, col_p;
  logic [7:0] mask_calc;
  logic [3:0] count_calc;
  logic       self_bit, alive_calc;

  assign col9 = {1'b0, item_r.col};
  assign row9 = {1'b0, item_r.row};

  // grid bounds
  assign col_ok  = col9 < 9'(GRID_COLS);
  assign row_ok  = row9 < 9'(GRID_ROWS);
  assign colm_ok = (item_r.col != 8'd0) && (col9 <= 9'(GRID_COLS));
  assign colp_ok = (col9 + 9'd1) < 9'(GRID_COLS);
  assign up_ok   = (item_r.row != 8'd0) && (row9 <= 9'(GRID_ROWS));
  assign dn_ok   = (row9 + 9'd1) < 9'(GRID_ROWS);

  // limit ring
  assign use_l = col9 > ({1'b0, x_low_r} + 9'd1);
  assign use_r = (col9 + 9'd1) < {1'b0, x_high_r};
  assign use_u = row9 > ({1'b0, y_low_r} + 9'd1);
  assign use_d = (row9 + 9'd1) < {1'b0, y_high_r};

  assign col_c = COL_W'(item_r.col);
  assign col_m = COL_W'(item_r.col - 8'd1);
  assign col_p = COL_W'(item_r.col + 8'd1);

  always_comb begin
    mask_calc[0] = use_l && use_u && up_ok && colm_ok && up_r[col_m];
    mask_calc[1] = use_u && up_ok && col_ok && up_r[col_c];
    mask_calc[2] = use_r && use_u && up_ok && colp_ok && up_r[col_p];
    mask_calc[3] = use_l && row_ok && colm_ok && mid_r[col_m];
    mask_calc[4] = use_r && row_ok && colp_ok && mid_r[col_p];
    mask_calc[5] = use_l && use_d && dn_ok && colm_ok && dn_r[col_m];
    mask_calc[6] = use_d && dn_ok && col_ok && dn_r[col_c];
    mask_calc[7] = use_r && use_d && dn_ok && colp_ok && dn_r[col_p];
    if (item_r.cmd != CMD_UPDATE) begin
      mask_calc = 8'd0;
    end
    count_calc = 4'($countones(mask_calc));
    self_bit   = row_ok && col_ok && mid_r[col_c];
    case (item_r.cmd)
      CMD_UPDATE: begin
        if (!self_bit && count_calc == BIRTH_CNT) begin
          alive_calc = 1'b1;
        end else if (count_calc < SURVIVE_MIN || count_calc > BIRTH_CNT) begin
          alive_calc = 1'b0;
        end else begin
          alive_calc = self_bit;
        end
      end
      CMD_WRITE: alive_calc = item_r.cell_value && row_ok && col_ok;
      default:   alive_calc = self_bit;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign wb_go = !out_valid_r || !out_stall;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ROW_W'(item_r.row);
    mem_wdata = mid_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_RD_UP: mem_addr = ROW_W'(item_r.row - 8'd1);
      ST_RD_DN: mem_addr = ROW_W'(item_r.row + 8'd1);
      ST_WB: begin
        mem_we = wb_go && row_ok && col_ok;
        mem_wdata[col_c] = alive_r;
      end
      default: mem_addr = ROW_W'(item_r.row);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else begin
      mem_q <= mem[mem_addr];
    end
  end

  // sequencer and control registers
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    x_low_nxt     = x_low_r;
    x_high_nxt    = x_high_r;
    y_low_nxt     = y_low_r;
    y_high_nxt    = y_high_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_X_LOW:  x_low_nxt  = cfg_wdata;
        REG_X_HIGH: x_high_nxt = cfg_wdata;
        REG_Y_LOW:  y_low_nxt  = cfg_wdata;
        REG_Y_HIGH: y_high_nxt = cfg_wdata;
        default:    x_low_nxt  = x_low_r;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_W'(GRID_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE:   if (accept) state_nxt = ST_RD_MID;
      ST_RD_MID: state_nxt = ST_RD_UP;
      ST_RD_UP:  state_nxt = ST_RD_DN;
      ST_RD_DN:  state_nxt = ST_CAP_DN;
      ST_CAP_DN: state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_WB;
      ST_WB: begin
        // hold until the previous beat has left the output register
        if (wb_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      x_low_r     <= X_LOW_RST;
      x_high_r    <= X_HIGH_RST;
      y_low_r     <= Y_LOW_RST;
      y_high_r    <= Y_HIGH_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      x_low_r     <= x_low_nxt;
      x_high_r    <= x_high_nxt;
      y_low_r     <= y_low_nxt;
      y_high_r    <= y_high_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == ST_RD_UP) begin
      mid_r <= mem_q;
    end
    if (state_r == ST_RD_DN) begin
      up_r <= mem_q;
    end
    if (state_r == ST_CAP_DN) begin
      dn_r <= mem_q;
    end
    if (state_r == ST_CALC) begin
      mask_r  <= mask_calc;
      count_r <= count_calc;
      alive_r <= alive_calc;
    end
    if (state_r == ST_WB && wb_go) begin
      out_data_r.alive          <= alive_r;
      out_data_r.live_count     <= count_r;
      out_data_r.neighbour_mask <= mask_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LCU_ASSERT_NEXT(a_accept_starts_read, accept, state_r == ST_RD_MID, "accepted beat did not start a row read")
  `LCU_ASSERT_NOW(a_no_accept_in_clear, state_r == ST_CLEAR, in_stall, "input taken during clearing pass")
  `LCU_ASSERT_NOW(a_write_states, mem_we, state_r == ST_CLEAR || state_r == ST_WB, "grid written outside clear or write-back")
  `LCU_ASSERT_NOW(a_count_matches_mask, out_valid_r, out_data_r.live_count == 4'($countones(out_data_r.neighbour_mask)), "live count disagrees with neighbour mask")
  `LCU_ASSERT_NEXT(a_wb_no_overwrite, state_r == ST_WB && out_valid_r && out_stall, state_r == ST_WB && out_valid_r, "pending result overwritten")

endmodule

[tb/life_cell_update_engine_tb.sv]
// Testbench for life_cell_update_engine: random and directed cell commands over a
// valid/stall channel, checked beat by beat against a grid predictor in a scoreboard.
// Depends on lcu_pkg and the life_cell_update_engine RTL.
`timescale 1ns / 1ps

module life_cell_update_engine_tb;
  import lcu_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;  // unused code, behaves as a read
  localparam int         NUM_PHASES  = 6;
  localparam int         PHASE_ITEMS = 230;
  localparam int         SETTLE      = 16;
  localparam int         CYCLE_LIMIT = 400000;

  class life_grid_scoreboard;
    bit         cells [65536];
    logic [7:0] x_lo = X_LOW_RST;
    logic [7:0] x_hi = X_HIGH_RST;
    logic [7:0] y_lo = Y_LOW_RST;
    logic [7:0] y_hi = Y_HIGH_RST;
    out_item_t  expected_q [$];
    int         errors = 0;

    function void set_limit(reg_idx_t idx, logic [7:0] v);
      case (idx)
        REG_X_LOW:  x_lo = v;
        REG_X_HIGH: x_hi = v;
        REG_Y_LOW:  y_lo = v;
        default:    y_hi = v;
      endcase
    endfunction

    function bit cell_at(int c, int r);
      if (c < 0 || r < 0 || c >= GRID_COLS || r >= GRID_ROWS) return 1'b0;
      return cells[r * GRID_COLS + c];
    endfunction

    function void cell_put(int c, int r, bit v);
      if (c < 0 || r < 0 || c >= GRID_COLS || r >= GRID_ROWS) return;
      cells[r * GRID_COLS + c] = v;
    endfunction

    // Apply one accepted command to the grid and queue the result it must produce.
    function void note_input(in_item_t it);
      int        dc [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
      int        dr [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
      int        c, r, cnt;
      bit        use_l, use_r, use_u, use_d;
      bit [7:0]  use_k, mask;
      out_item_t want;
      c    = it.col;
      r    = it.row;
      cnt  = 0;
      mask = '0;
      if (it.cmd == CMD_UPDATE) begin
        // neighbours on or past a limit line count as dead
        use_l = c > int'(x_lo) + 1;
        use_r = c < int'(x_hi) - 1;
        use_u = r > int'(y_lo) + 1;
        use_d = r < int'(y_hi) - 1;
        use_k = {use_r && use_d, use_d, use_l && use_d, use_r, use_l,
                 use_r && use_u, use_u, use_l && use_u};
        for (int k = 0; k < 8; k++) begin
          if (use_k[k] && cell_at(c + dc[k], r + dr[k])) begin
            mask[k] = 1'b1;
            cnt++;
          end
        end
        if (!cell_at(c, r) && cnt == int'(BIRTH_CNT)) cell_put(c, r, 1'b1);
        else if (cnt < int'(SURVIVE_MIN) || cnt > int'(BIRTH_CNT)) cell_put(c, r, 1'b0);
      end else if (it.cmd == CMD_WRITE) begin
        cell_put(c, r, it.cell_value);
      end
      want.alive          = cell_at(c, r);
      want.live_count     = 4'(cnt);
      want.neighbour_mask = mask;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("alive", 8'(want.alive), 8'(got.alive));
      compare_field("live_count", 8'(want.live_count), 8'(got.live_count));
      compare_field("neighbour_mask", want.neighbour_mask, got.neighbour_mask);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  life_grid_scoreboard sb = new;
  bit idle_on = 1'b1;
  int cycle_count = 0;

  life_cell_update_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Accepted beats on both channels feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver back-pressure in random bursts.
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t item);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input int c, input int r, input bit v);
    in_item_t it;
    it.cmd        = cmd;
    it.col        = 8'(c);
    it.row        = 8'(r);
    it.cell_value = v;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_limit(idx, v);
  endtask

  task automatic apply_limits(input logic [7:0] xl, input logic [7:0] xh,
                              input logic [7:0] yl, input logic [7:0] yh);
    drain_results();
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_HIGH, xh);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_HIGH, yh);
    cfg_we <= 1'b0;
  endtask

  // Window origin near a limit line, a grid edge, or anywhere.
  function automatic int pick_base(input int lo, input int hi);
    int b;
    case ($urandom_range(0, 3))
      0:       b = lo - 3;
      1:       b = hi - 5;
      2:       b = $urandom_range(0, 248);
      default: b = $urandom_range(0, 1) ? 0 : 248;
    endcase
    if (b < 0) b = 0;
    if (b > 248) b = 248;
    return b;
  endfunction

  // Mostly dense traffic inside an 8x8 window so neighbourhoods fill up.
  function automatic in_item_t rand_item(input int bx, input int by);
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.cmd = CMD_UPDATE;
    else if (pick < 80) it.cmd = CMD_WRITE;
    else if (pick < 95) it.cmd = CMD_READ;
    else                it.cmd = CMD_SPARE;
    if ($urandom_range(0, 99) < 85) begin
      it.col = 8'(bx + $urandom_range(0, 7));
      it.row = 8'(by + $urandom_range(0, 7));
    end else begin
      it.col = 8'($urandom_range(0, 255));
      it.row = 8'($urandom_range(0, 255));
    end
    it.cell_value = ($urandom_range(0, 99) < 60);
    return it;
  endfunction

  task automatic run_directed();
    send_cmd(CMD_READ, 0, 0, 1'b0);
    send_cmd(CMD_WRITE, 255, 255, 1'b1);
    send_cmd(CMD_SPARE, 255, 255, 1'b0);
    send_cmd(CMD_UPDATE, 255, 255, 1'b0);
    send_cmd(CMD_WRITE, 0, 0, 1'b1);
    send_cmd(CMD_UPDATE, 0, 0, 1'b0);
    // three in a row: birth above and below, survival in the middle
    send_cmd(CMD_WRITE, 11, 10, 1'b1);
    send_cmd(CMD_WRITE, 12, 10, 1'b1);
    send_cmd(CMD_WRITE, 13, 10, 1'b1);
    send_cmd(CMD_UPDATE, 12, 11, 1'b0);
    send_cmd(CMD_UPDATE, 12, 10, 1'b0);
    send_cmd(CMD_UPDATE, 12, 9, 1'b0);
    // full ring of eight: overcrowding
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (dx != 0 || dy != 0) send_cmd(CMD_WRITE, 20 + dx, 20 + dy, 1'b1);
      end
    end
    send_cmd(CMD_UPDATE, 20, 20, 1'b0);
    send_cmd(CMD_UPDATE, 20, 20, 1'b0);
  endtask

  initial begin
    int bx, by;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_X_LOW;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    bx = 0;
    by = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: apply_limits(8'd0, 8'd255, 8'd0, 8'd255);
        2: apply_limits(8'd255, 8'd0, 8'd255, 8'd0);
        3: apply_limits(8'd100, 8'd108, 8'd50, 8'd58);
        4: apply_limits(8'($urandom_range(0, 40)), 8'($urandom_range(200, 255)),
                        8'($urandom_range(0, 40)), 8'($urandom_range(200, 255)));
        5: apply_limits(8'd1, 8'd254, 8'd2, 8'd253);
        default: run_directed();
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 30 == 0) begin
          bx = pick_base(sb.x_lo, sb.x_hi);
          by = pick_base(sb.y_lo, sb.y_hi);
        end
        // quiet stretches inside phases, none at all in the last one
        idle_on = (p != NUM_PHASES - 1) && ((i / 50) % 4 != 3);
        send_item(rand_item(bx, by));
      end
    end
    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[life_cell_update_engine.f]
+incdir+hw/rtl
hw/rtl/lcu_pkg.sv
hw/rtl/life_cell_update_engine.sv
tb/life_cell_update_engine_tb.sv
